// File: hdl/zscore_peak_step_counter_unit_defines.svh
// Assertion macros shared by the step counter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ZSCORE_PEAK_STEP_COUNTER_UNIT_DEFINES_SVH
`define ZSCORE_PEAK_STEP_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication on i_clk, held off during reset.
`define ZSPK_CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zspk check failed");

// Next-cycle implication on i_clk, held off during reset.
`define ZSPK_CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zspk check failed");

`endif

// File: hdl/zspk_pkg.sv
// Shared constants and types of the z-score step counter.
// No dependencies; used by the multiplier, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none
package zspk_pkg;
    localparam int MAX_LAG       = 64;
    localparam int MAX_WINDOW    = 256;
    localparam int FRACTION_BITS = 8;
    localparam int LAG_AW        = $clog2(MAX_LAG);
    localparam int SMP_W         = 16;
    localparam int VAL_W         = SMP_W + FRACTION_BITS;
    localparam int SUM_W         = VAL_W + LAG_AW;
    localparam int SQ_W          = 2 * VAL_W + LAG_AW;
    localparam int POS_W         = $clog2(MAX_WINDOW) + 1;

    localparam int LIM           = 100 * (2 ** FRACTION_BITS);
    localparam logic [63:0] LIM_SQ = 64'(LIM) * 64'(LIM);

    localparam int MUL_AW = 64;
    localparam int MUL_BW = 40;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW);

    localparam int DIV_NW = VAL_W + 2;
    localparam int DIV_W  = DIV_NW + 1;
    localparam int DIV_CW = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(3) << (DIV_NW - 1);

    typedef enum logic [1:0] {
        CFG_LAG = 2'd0,
        CFG_THR = 2'd1,
        CFG_INF = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [MUL_CW:0]   nbits;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;
endpackage
`default_nettype wire

// File: hdl/zspk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module zspk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/zspk_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on zspk_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module zspk_mul (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  zspk_pkg::t_mul_req           i_req,
    output logic                         o_done,
    output logic [zspk_pkg::MUL_PW-1:0]  o_prod
);
    logic [zspk_pkg::MUL_AW-1:0] r_a;
    logic [zspk_pkg::MUL_BW-1:0] r_b;
    logic [zspk_pkg::MUL_CW-1:0] r_idx;
    logic                        r_busy;
    logic                        r_done;
    logic [zspk_pkg::MUL_PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_idx  <= zspk_pkg::MUL_CW'(i_req.nbits - 1'b1);
                r_acc  <= '0;
            end else if (r_busy) begin
                // shift and add the operand when this multiplier bit is set
                r_acc <= (r_acc << 1)
                       + (r_b[r_idx] ? zspk_pkg::MUL_PW'(r_a) : '0);
                r_idx <= r_idx - 1'b1;
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// File: hdl/zspk_div3.sv
// Bit-serial floor division of a signed value by three, one bit per cycle.
// Depends on zspk_pkg for widths and the bias constant.
`timescale 1ns / 1ps
`default_nettype none
module zspk_div3 (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire signed [zspk_pkg::DIV_NW-1:0]   i_num,
    output logic                                o_done,
    output logic signed [zspk_pkg::VAL_W-1:0]   o_quot
);
    logic [zspk_pkg::DIV_W-1:0]  r_u;
    logic [zspk_pkg::DIV_W-1:0]  r_q;
    logic [1:0]                  r_rem;
    logic [zspk_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [2:0]                  w_trial;

    // bias keeps the dividend positive; floor then falls out of the unsigned quotient
    assign w_trial = {r_rem, r_u[zspk_pkg::DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_u    <= zspk_pkg::DIV_W'(i_num) + zspk_pkg::DIV_BIAS;
                r_q    <= '0;
                r_rem  <= '0;
                r_cnt  <= zspk_pkg::DIV_CW'(zspk_pkg::DIV_W - 1);
            end else if (r_busy) begin
                r_u <= r_u << 1;
                if (w_trial >= 3'd3) begin
                    r_rem <= 2'(w_trial - 3'd3);
                    r_q   <= {r_q[zspk_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[1:0];
                    r_q   <= {r_q[zspk_pkg::DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = $signed(zspk_pkg::VAL_W'(r_q - (zspk_pkg::DIV_BIAS / 3)));
endmodule
`default_nettype wire

// File: hdl/zscore_peak_step_counter_unit.sv
// Top level of the z-score peak detecting step counter.
// Depends on zspk_pkg, zspk_ram, zspk_mul and zspk_div3.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_sample, i_window_end
//  result    out        o_out_valid / i_out_ready  o_peak_signal, o_steps_counted,
//                                                  o_window_done
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word at a time: the first two words of a window take one product, later words a
// serial divide by three and then one product until the lag window fills, eight once
// statistics run and eleven on a peak, all in the shared bit-serial multiplier, one
// multiplier bit per cycle.
// Synchronous active-low reset clears control state; the history RAM needs no clear.
// A result waits in the output register; a stalled consumer holds the block only
// when the next result is ready to be written back.
`timescale 1ns / 1ps
`default_nettype none
module zscore_peak_step_counter_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  signed [15:0] i_sample,
    input  wire         i_window_end,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic signed [1:0] o_peak_signal,
    output logic [8:0]  o_steps_counted,
    output logic        o_window_done,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [11:0] i_cfg_data
);
    localparam int VW = zspk_pkg::VAL_W;
    localparam int SW = zspk_pkg::SUM_W;
    localparam int QW = zspk_pkg::SQ_W;
    localparam int PW = zspk_pkg::POS_W;
    localparam int AW = zspk_pkg::LAG_AW;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_ISSUE  = 5'b00100,
        S_WAIT   = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        OP_LS, OP_ASQ, OP_LS2, OP_ADQ, OP_THQ, OP_TDV,
        OP_LLQ, OP_LIM, OP_INF, OP_OLD, OP_FSQ
    } t_op;

    t_state r_state;
    t_op    r_op;

    // configuration
    logic [6:0]  r_cfg_lag;
    logic [11:0] r_cfg_thr;
    logic [8:0]  r_cfg_inf;

    // window state
    logic signed [VW-1:0] r_p1, r_p2, r_lf, r_s, r_f;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]        r_sq;
    logic [PW-1:0]        r_pos;
    logic [6:0]           r_lag;
    logic [AW-1:0]        r_wslot;
    logic signed [1:0]    r_last_sig, r_sig;
    logic [8:0]           r_steps;
    logic                 r_end, r_stats, r_stepok;

    // statistics scratch
    logic signed [31:0]   r_diff;
    logic [59:0]          r_asq;
    logic [63:0]          r_dev;
    logic [71:0]          r_adq;
    logic [23:0]          r_thq;
    logic [12:0]          r_llq;
    logic [47:0]          r_old2, r_f2;

    logic                 r_out_valid;
    logic signed [1:0]    r_out_sig;
    logic [8:0]           r_out_steps;
    logic                 r_out_end;

    logic                 w_accept;
    logic signed [VW-1:0] w_scaled;
    logic signed [zspk_pkg::DIV_NW-1:0] w_num;
    logic signed [VW:0]   w_half_sum;
    logic                 w_div_done;
    logic signed [VW-1:0] w_quot;
    zspk_pkg::t_mul_req   w_req;
    logic                 w_mul_done;
    logic [zspk_pkg::MUL_PW-1:0] w_prod;
    logic [VW-1:0]        w_old_raw;
    logic signed [VW-1:0] w_old;
    logic [VW-1:0]        w_abs_s, w_abs_f, w_abs_old;
    logic [SW-1:0]        w_asum;
    logic signed [31:0]   w_ls, w_diff;
    logic [31:0]          w_abs_diff;
    logic signed [VW:0]   w_d;
    logic [VW:0]          w_abs_d;
    logic [8:0]           w_inf;
    logic [33:0]          w_m;
    logic signed [VW+1:0] w_adj;
    logic [63:0]          w_lhs;
    logic [6:0]           w_lag_clamped;
    logic signed [SW-1:0] w_sum_next;
    logic [QW-1:0]        w_sq_next;
    logic [8:0]           w_steps_next;
    logic                 w_out_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // hold configuration; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lag <= 7'd16;
            r_cfg_thr <= 12'd56;
            r_cfg_inf <= 9'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                zspk_pkg::CFG_LAG: r_cfg_lag <= i_cfg_data[6:0];
                zspk_pkg::CFG_THR: r_cfg_thr <= i_cfg_data;
                zspk_pkg::CFG_INF: r_cfg_inf <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_lag_clamped = (r_cfg_lag < 7'd2) ? 7'd2 :
                           (r_cfg_lag > 7'(zspk_pkg::MAX_LAG)) ? 7'(zspk_pkg::MAX_LAG) :
                           r_cfg_lag;

    // smoothing arithmetic on the incoming word
    assign w_scaled   = $signed({i_sample, {zspk_pkg::FRACTION_BITS{1'b0}}});
    assign w_num      = zspk_pkg::DIV_NW'(w_scaled) + zspk_pkg::DIV_NW'(r_p1)
                      + zspk_pkg::DIV_NW'(r_p2);
    assign w_half_sum = (VW+1)'(w_scaled) + (VW+1)'(r_p1);

    zspk_div3 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (r_pos >= PW'(2))),
        .i_num   (w_num),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    zspk_ram #(.WIDTH(VW), .DEPTH(zspk_pkg::MAX_LAG)) u_hist (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_UPDATE) && w_out_free),
        .i_waddr (r_wslot),
        .i_wdata (r_f),
        .i_raddr (r_wslot),
        .o_rdata (w_old_raw)
    );

    assign w_old     = $signed(w_old_raw);
    assign w_abs_s   = r_s[VW-1] ? VW'(-r_s) : VW'(r_s);
    assign w_abs_f   = r_f[VW-1] ? VW'(-r_f) : VW'(r_f);
    assign w_abs_old = w_old[VW-1] ? VW'(-w_old) : VW'(w_old);
    assign w_asum    = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_d       = (VW+1)'(r_s) - (VW+1)'(r_lf);
    assign w_abs_d   = w_d[VW] ? (VW+1)'(-w_d) : (VW+1)'(w_d);
    assign w_inf     = (r_cfg_inf > 9'd256) ? 9'd256 : r_cfg_inf;

    // operand selection for the shared multiplier
    always_comb begin
        w_req       = '0;
        w_req.start = (r_state == S_ISSUE);
        unique case (r_op)
            OP_LS:  begin w_req.a = 64'(w_abs_s);  w_req.b = 40'(r_lag);  w_req.nbits = 7'd7;  end
            OP_ASQ: begin w_req.a = 64'(w_asum);   w_req.b = 40'(w_asum); w_req.nbits = 7'd30; end
            OP_LS2: begin w_req.a = 64'(r_sq);     w_req.b = 40'(r_lag);  w_req.nbits = 7'd7;  end
            OP_ADQ: begin
                w_req.a = 64'({w_abs_diff, 4'b0});
                w_req.b = 40'({w_abs_diff, 4'b0});
                w_req.nbits = 7'd36;
            end
            OP_THQ: begin w_req.a = 64'(r_cfg_thr); w_req.b = 40'(r_cfg_thr); w_req.nbits = 7'd12; end
            OP_TDV: begin w_req.a = r_dev;          w_req.b = 40'(r_thq);     w_req.nbits = 7'd24; end
            OP_LLQ: begin w_req.a = 64'(r_lag);     w_req.b = 40'(r_lag);     w_req.nbits = 7'd7;  end
            OP_LIM: begin w_req.a = zspk_pkg::LIM_SQ; w_req.b = 40'(r_llq);   w_req.nbits = 7'd13; end
            OP_INF: begin w_req.a = 64'(w_abs_d);   w_req.b = 40'(w_inf);     w_req.nbits = 7'd9;  end
            OP_OLD: begin w_req.a = 64'(w_abs_old); w_req.b = 40'(w_abs_old); w_req.nbits = 7'd24; end
            OP_FSQ: begin w_req.a = 64'(w_abs_f);   w_req.b = 40'(w_abs_f);   w_req.nbits = 7'd24; end
            default: ;
        endcase
    end

    zspk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // results that follow straight from a finished product
    assign w_ls       = r_s[VW-1] ? -$signed({1'b0, w_prod[30:0]}) : $signed({1'b0, w_prod[30:0]});
    assign w_diff     = w_ls - 32'(r_sum);
    assign w_abs_diff = r_diff[31] ? 32'(-r_diff) : 32'(r_diff);
    assign w_lhs      = w_prod[63:0];
    assign w_m        = w_prod[33:0];
    assign w_adj      = w_d[VW] ? -$signed({2'b0, VW'((w_m + 34'd255) >> 8)})
                                :  $signed({2'b0, VW'(w_m >> 8)});

    assign w_sum_next = r_stats ? r_sum - SW'(w_old) + SW'(r_f) : r_sum + SW'(r_f);
    assign w_sq_next  = r_stats ? r_sq - QW'(r_old2) + QW'(r_f2) : r_sq + QW'(r_f2);
    assign w_steps_next = ((r_sig != 2'sd0) && r_stepok && (r_last_sig != 2'sd1)
                          && (r_steps < 9'd256)) ? r_steps + 1'b1 : r_steps;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FSQ;
            r_p1        <= '0;
            r_p2        <= '0;
            r_lf        <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_pos       <= '0;
            r_lag       <= 7'd16;
            r_wslot     <= '0;
            r_last_sig  <= '0;
            r_sig       <= '0;
            r_steps     <= '0;
            r_stats     <= 1'b0;
            r_stepok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_end    <= i_window_end;
                        r_sig    <= '0;
                        r_stepok <= 1'b0;
                        r_stats  <= 1'b0;
                        if (r_pos == '0) begin
                            r_lag   <= w_lag_clamped;
                            r_wslot <= '0;
                        end
                        if (r_pos >= PW'(2)) begin
                            r_state <= S_DIV;
                        end else begin
                            // early samples skip the divide and the peak test
                            if (r_pos == '0) begin
                                r_s <= w_scaled;
                                r_f <= w_scaled;
                                r_p1 <= w_scaled;
                            end else begin
                                r_s <= VW'(w_half_sum >>> 1);
                                r_f <= VW'(w_half_sum >>> 1);
                                r_p1 <= VW'(w_half_sum >>> 1);
                            end
                            r_p2    <= r_p1;
                            r_op    <= OP_FSQ;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_s     <= w_quot;
                        r_f     <= w_quot;
                        r_p1    <= w_quot;
                        r_p2    <= r_p1;
                        r_stats <= (r_pos >= PW'(r_lag));
                        r_op    <= (r_pos >= PW'(r_lag)) ? OP_LS : OP_FSQ;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mul_done) begin
                        r_state <= S_ISSUE;
                        unique case (r_op)
                            OP_LS:  begin r_diff <= w_diff;         r_op <= OP_ASQ; end
                            OP_ASQ: begin r_asq  <= w_prod[59:0];   r_op <= OP_LS2; end
                            OP_LS2: begin
                                r_dev <= (w_lhs > 64'(r_asq)) ? w_lhs - 64'(r_asq) : '0;
                                r_op  <= OP_ADQ;
                            end
                            OP_ADQ: begin r_adq <= w_prod[71:0];   r_op <= OP_THQ; end
                            OP_THQ: begin r_thq <= w_prod[23:0];   r_op <= OP_TDV; end
                            OP_TDV: begin
                                // peak when the squared distance beats the squared threshold times variance
                                if (zspk_pkg::MUL_PW'(r_adq) > w_prod) begin
                                    r_sig <= (r_diff > 32'sd0) ? 2'sd1 : -2'sd1;
                                    r_op  <= OP_LLQ;
                                end else begin
                                    r_op  <= OP_OLD;
                                end
                            end
                            OP_LLQ: begin r_llq <= w_prod[12:0];   r_op <= OP_LIM; end
                            OP_LIM: begin r_stepok <= (r_dev > w_lhs); r_op <= OP_INF; end
                            OP_INF: begin
                                r_f  <= VW'((VW+2)'(r_lf) + w_adj);
                                r_op <= OP_OLD;
                            end
                            OP_OLD: begin r_old2 <= w_prod[47:0];  r_op <= OP_FSQ; end
                            OP_FSQ: begin r_f2   <= w_prod[47:0];  r_state <= S_UPDATE; end
                            default: ;
                        endcase
                    end
                end
                S_UPDATE: begin
                    // hold until the output register can take the word
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sig   <= r_sig;
                        r_out_steps <= w_steps_next;
                        r_out_end   <= r_end;
                        r_state     <= S_IDLE;
                        if (r_end) begin
                            r_p1       <= '0;
                            r_p2       <= '0;
                            r_lf       <= '0;
                            r_sum      <= '0;
                            r_sq       <= '0;
                            r_pos      <= '0;
                            r_wslot    <= '0;
                            r_last_sig <= '0;
                            r_steps    <= '0;
                        end else begin
                            r_sum      <= w_sum_next;
                            r_sq       <= w_sq_next;
                            r_lf       <= r_f;
                            r_last_sig <= r_sig;
                            r_steps    <= w_steps_next;
                            r_wslot    <= (7'(r_wslot) + 7'd1 >= r_lag) ? '0 : r_wslot + 1'b1;
                            if (r_pos < PW'(zspk_pkg::MAX_WINDOW)) begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_signal   = r_out_sig;
    assign o_steps_counted = r_out_steps;
    assign o_window_done   = r_out_end;
endmodule
`default_nettype wire

// File: hdl/zspk_checker.sv
// Port-level checker for the step counter, bound to the top level.
// Depends on zscore_peak_step_counter_unit_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "zscore_peak_step_counter_unit_defines.svh"
module zspk_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              o_in_ready,
    input wire signed [15:0] i_sample,
    input wire              i_window_end,
    input wire              o_out_valid,
    input wire              i_out_ready,
    input wire signed [1:0] o_peak_signal,
    input wire [8:0]        o_steps_counted,
    input wire              o_window_done
);
    logic [16:0] w_in_word;
    logic [11:0] w_out_word;

    assign w_in_word  = {i_sample, i_window_end};
    assign w_out_word = {o_peak_signal, o_steps_counted, o_window_done};

    `ZSPK_CHK_NOW(a_sig_code, o_out_valid, o_peak_signal != 2'b10)
    `ZSPK_CHK_NOW(a_steps_max, o_out_valid, o_steps_counted <= 9'd256)
    `ZSPK_CHK_NEXT(a_one_word, i_in_valid && o_in_ready, !o_in_ready)
    `ZSPK_CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(w_out_word))
    `ZSPK_CHK_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(w_in_word))
endmodule

bind zscore_peak_step_counter_unit zspk_checker u_zspk_checker (.*);
`default_nettype wire
